// ===== hdl/two_ball_collision_step_unit_assert.svh =====
// assertion macros for the collision step unit
`ifndef TWO_BALL_COLLISION_STEP_UNIT_ASSERT_SVH
`define TWO_BALL_COLLISION_STEP_UNIT_ASSERT_SVH

// property a must imply b in the next cycle
`define TBC_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tbc next-cycle check failed");

// property a must imply b in the same cycle
`define TBC_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tbc same-cycle check failed");

`endif

// ===== hdl/tbc_pkg.sv =====
package tbc_pkg;

  localparam int unsigned BOUNCE_Q16 = 58982;

  typedef struct packed {
    logic        opcode;
    logic [15:0] delta_time;
    logic [7:0]  keys_down;
    logic        ball_select;
    logic signed [31:0] place_x;
    logic signed [31:0] place_y;
    logic signed [31:0] place_vx;
    logic signed [31:0] place_vy;
  } tbc_in_t;

  typedef struct packed {
    logic signed [31:0] out_a_x;
    logic signed [31:0] out_a_y;
    logic signed [31:0] out_b_x;
    logic signed [31:0] out_b_y;
    logic               collided;
  } tbc_out_t;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  localparam logic [2:0] REG_RADIUS_A = 3'd0;
  localparam logic [2:0] REG_RADIUS_B = 3'd1;
  localparam logic [2:0] REG_FIELD_W  = 3'd2;
  localparam logic [2:0] REG_FIELD_H  = 3'd3;
  localparam logic [2:0] REG_KEY_SPD  = 3'd4;
  localparam logic [2:0] REG_FRICTION = 3'd5;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] mx;
    logic signed [71:0] mn;
    mx = 72'sd2147483647;
    mn = -72'sd2147483648;
    if (v > mx) return 32'sh7fffffff;
    if (v < mn) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== hdl/two_ball_collision_step_unit.sv =====
// Two-ball physics frame unit. A place word loads one ball's position and
// velocity; a tick word runs one frame (key moves, wall clamp, integration,
// circle overlap with separation and damped impulse, wall clamp, friction)
// and returns both positions plus a collided flag. All products but the wall
// bounce run through one shared signed multiplier (34x34, operands as
// magnitudes with the product truncated toward zero), one shared restoring
// square root (one result bit a cycle) and one shared restoring divider (one
// quotient bit a cycle), under a small sequencer. A place word loads its ball
// and passes through the done state to its result. Every tick runs the 33-step
// square root; when the balls touch without sharing a center it also runs two
// 49-step divisions, and the damped impulse steps follow when the balls are
// not moving apart. The unit takes no new word until the result has been
// taken.
module two_ball_collision_step_unit import tbc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  tbc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tbc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int DW = 32 + FRAC_BITS + 1; // dividend width for normals

  // sequencer codes
  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_KMV    = 6'd1;  // mv = key_speed*dt
  localparam logic [5:0] S_KEYS   = 6'd2;
  localparam logic [5:0] S_WALL   = 6'd3;  // 4 axes via idx
  localparam logic [5:0] S_INTM   = 6'd4;  // pos += v*dt, idx
  localparam logic [5:0] S_DIFF   = 6'd5;
  localparam logic [5:0] S_SQX    = 6'd6;
  localparam logic [5:0] S_SQY    = 6'd7;
  localparam logic [5:0] S_SQRT   = 6'd8;
  localparam logic [5:0] S_TEST   = 6'd9;
  localparam logic [5:0] S_DIVX   = 6'd10;
  localparam logic [5:0] S_DIVY   = 6'd11;
  localparam logic [5:0] S_SEPX   = 6'd12;
  localparam logic [5:0] S_SEPY   = 6'd13;
  localparam logic [5:0] S_DOTX   = 6'd14;
  localparam logic [5:0] S_DOTY   = 6'd15;
  localparam logic [5:0] S_IMP    = 6'd16;
  localparam logic [5:0] S_IMPX   = 6'd17;
  localparam logic [5:0] S_IMPY   = 6'd18;
  localparam logic [5:0] S_WALL2  = 6'd19;
  localparam logic [5:0] S_FRIC   = 6'd20;
  localparam logic [5:0] S_DONE   = 6'd21;

  // configuration registers
  logic [9:0]  radius_a, radius_b;
  logic [11:0] field_width, field_height;
  logic [23:0] key_speed;
  logic [16:0] friction_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_a <= 10'd40;
      radius_b <= 10'd40;
      field_width <= 12'd800;
      field_height <= 12'd600;
      key_speed <= 24'd13107200;
      friction_factor <= 17'd64880;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS_A: radius_a <= cfg_data[9:0];
        REG_RADIUS_B: radius_b <= cfg_data[9:0];
        REG_FIELD_W:  field_width <= cfg_data[11:0];
        REG_FIELD_H:  field_height <= cfg_data[11:0];
        REG_KEY_SPD:  key_speed <= cfg_data;
        REG_FRICTION: friction_factor <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // ball state: index 0 a_x, 1 a_y, 2 b_x, 3 b_y
  logic signed [31:0] pos [4];
  logic signed [31:0] vel [4];

  logic [5:0] state;
  logic [1:0] idx;
  tbc_in_t    item;
  logic       hit;
  logic signed [63:0] mv;
  logic signed [32:0] dx, dy;
  logic [64:0]        sq;
  logic signed [FRAC_BITS+1:0] nx, ny;
  logic signed [65:0] half;
  logic signed [65:0] dot;
  logic signed [65:0] imp;

  // shared multiplier: |a|*|b| >> sh, sign restored
  logic signed [66:0] ma, mb;
  logic [5:0]         msh;
  logic [133:0]       mprod;
  logic signed [71:0] mres;
  always_comb begin
    logic [66:0] aa, bb;
    aa = ma[66] ? 67'(-ma) : 67'(ma);
    bb = mb[66] ? 67'(-mb) : 67'(mb);
    mprod = (aa[33:0] * bb[33:0]) >> msh;
    mres = (ma[66] != mb[66]) ? -72'(signed'({1'b0, mprod[70:0]}))
                              : 72'(signed'({1'b0, mprod[70:0]}));
  end

  // square root unit
  logic [64:0] sr_n, sr_res, sr_bit;
  logic        sr_busy;
  // divider unit: magnitude quotient of num / den
  logic [DW-1:0] dv_rem_n;
  logic [DW:0]   dv_q;
  logic [DW:0]   dv_r;
  logic [63:0]   dv_den;
  logic [6:0]    dv_cnt;
  logic          dv_neg;
  logic          dv_busy;

  // wall helper for current axis
  function automatic void wall_calc(input logic signed [31:0] p, input logic signed [31:0] v,
                                    input logic [9:0] r, input logic [11:0] lim,
                                    output logic signed [31:0] po,
                                    output logic signed [31:0] vo);
    logic signed [71:0] lo, hi, s;
    logic [31:0] av;
    logic [63:0] pr;
    lo = 72'(signed'({1'b0, r})) <<< FRAC_BITS;
    hi = (72'(signed'({1'b0, lim})) - 72'(signed'({1'b0, r}))) <<< FRAC_BITS;
    av = v[31] ? 32'(-v) : 32'(v);
    pr = (64'(av) * 64'(BOUNCE_Q16)) >> 16;
    s = 72'(pr);
    po = p;
    vo = v;
    if (72'(p) < lo) begin
      po = sat32(lo);
      vo = sat32(s);
    end else if (72'(p) > hi) begin
      po = sat32(hi);
      vo = sat32(-s);
    end
  endfunction

  logic signed [31:0] w_po, w_vo;
  always_comb begin
    logic [9:0] r;
    logic [11:0] lim;
    r = idx[1] ? radius_b : radius_a;
    lim = idx[0] ? field_height : field_width;
    wall_calc(pos[idx], vel[idx], r, lim, w_po, w_vo);
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    msh = 6'd16;
    unique case (state)
      S_KMV: begin
        ma = 67'(signed'({1'b0, key_speed}));
        mb = 67'(signed'({1'b0, item.delta_time}));
      end
      S_INTM: begin
        ma = 67'(vel[idx]);
        mb = 67'(signed'({1'b0, item.delta_time}));
      end
      S_SQX: begin
        ma = 67'(dx);
        mb = 67'(dx);
        msh = 6'd0;
      end
      S_SQY: begin
        ma = 67'(dy);
        mb = 67'(dy);
        msh = 6'd0;
      end
      S_SEPX: begin
        ma = 67'(nx);
        mb = 67'(half);
        msh = 6'(FRAC_BITS);
      end
      S_SEPY: begin
        ma = 67'(ny);
        mb = 67'(half);
        msh = 6'(FRAC_BITS);
      end
      S_DOTX: begin
        ma = 67'(vel[2]) - 67'(vel[0]);
        mb = 67'(nx);
        msh = 6'(FRAC_BITS);
      end
      S_DOTY: begin
        ma = 67'(vel[3]) - 67'(vel[1]);
        mb = 67'(ny);
        msh = 6'(FRAC_BITS);
      end
      S_IMP: begin
        ma = 67'(dot);
        mb = 67'(BOUNCE_Q16);
      end
      S_IMPX: begin
        ma = 67'(imp);
        mb = 67'(nx);
        msh = 6'(FRAC_BITS);
      end
      S_IMPY: begin
        ma = 67'(imp);
        mb = 67'(ny);
        msh = 6'(FRAC_BITS);
      end
      S_FRIC: begin
        ma = 67'(vel[idx]);
        mb = 67'(signed'({1'b0, friction_factor}));
      end
      default: ;
    endcase
  end

  logic signed [71:0] rsum;
  assign rsum = 72'(signed'({1'b0, 11'(radius_a) + 11'(radius_b)})) <<< FRAC_BITS;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      sr_busy <= 1'b0;
      dv_busy <= 1'b0;
      idx <= '0;
      for (int i = 0; i < 4; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            hit <= 1'b0;
            idx <= '0;
            if (in_data.opcode == OP_PLACE) begin
              if (in_data.ball_select) begin
                pos[2] <= in_data.place_x;
                pos[3] <= in_data.place_y;
                vel[2] <= in_data.place_vx;
                vel[3] <= in_data.place_vy;
              end else begin
                pos[0] <= in_data.place_x;
                pos[1] <= in_data.place_y;
                vel[0] <= in_data.place_vx;
                vel[1] <= in_data.place_vy;
              end
              state <= S_DONE;
            end else begin
              state <= S_KMV;
            end
          end
        end
        S_KMV: begin
          mv <= mres[63:0];
          state <= S_KEYS;
        end
        S_KEYS: begin
          for (int b = 0; b < 2; b++) begin
            logic signed [31:0] px, py;
            logic [3:0] k;
            k = item.keys_down[4*b +: 4];
            px = pos[2*b];
            py = pos[2*b+1];
            if (k[0]) px = sat32(72'(px) + 72'(mv));
            if (k[1]) px = sat32(72'(px) - 72'(mv));
            if (k[2]) py = sat32(72'(py) - 72'(mv));
            if (k[3]) py = sat32(72'(py) + 72'(mv));
            pos[2*b] <= px;
            pos[2*b+1] <= py;
          end
          state <= S_WALL;
        end
        S_WALL, S_WALL2: begin
          pos[idx] <= w_po;
          vel[idx] <= w_vo;
          idx <= idx + 2'd1;
          if (idx == 2'd3) state <= (state == S_WALL) ? S_INTM : S_FRIC;
        end
        S_INTM: begin
          pos[idx] <= sat32(72'(pos[idx]) + mres);
          idx <= idx + 2'd1;
          if (idx == 2'd3) state <= S_DIFF;
        end
        S_DIFF: begin
          dx <= 33'(sat32(72'(pos[2]) - 72'(pos[0])));
          dy <= 33'(sat32(72'(pos[3]) - 72'(pos[1])));
          state <= S_SQX;
        end
        S_SQX: begin
          sq <= 65'(mprod);
          state <= S_SQY;
        end
        S_SQY: begin
          sr_n <= sq + 65'(mprod);
          sr_res <= '0;
          sr_bit <= 65'd1 << 64;
          sr_busy <= 1'b1;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sr_bit == '0) begin
            sr_busy <= 1'b0;
            state <= S_TEST;
          end else begin
            if (sr_n >= sr_res + sr_bit) begin
              sr_n <= sr_n - (sr_res + sr_bit);
              sr_res <= (sr_res >> 1) + sr_bit;
            end else begin
              sr_res <= sr_res >> 1;
            end
            sr_bit <= sr_bit >> 2;
          end
        end
        S_TEST: begin
          if (72'(sr_res) > rsum) begin
            state <= S_WALL2;
          end else if (sr_res == '0) begin
            hit <= 1'b1;
            state <= S_WALL2;
          end else begin
            hit <= 1'b1;
            half <= 66'((rsum - 72'(sr_res)) >>> 1);
            dv_rem_n <= DW'(dx[32] ? 33'(-dx) : dx) << FRAC_BITS;
            dv_neg <= dx[32];
            dv_den <= sr_res[63:0];
            dv_r <= '0;
            dv_q <= '0;
            dv_cnt <= 7'(DW);
            dv_busy <= 1'b1;
            state <= S_DIVX;
          end
        end
        S_DIVX, S_DIVY: begin
          if (dv_cnt != '0) begin
            logic [DW+64:0] rr;
            rr = {dv_r, dv_rem_n[DW-1]};
            if (rr >= (DW+65)'(dv_den)) begin
              dv_r <= (DW+1)'(rr - (DW+65)'(dv_den));
              dv_q <= {dv_q[DW-1:0], 1'b1};
            end else begin
              dv_r <= (DW+1)'(rr);
              dv_q <= {dv_q[DW-1:0], 1'b0};
            end
            dv_rem_n <= dv_rem_n << 1;
            dv_cnt <= dv_cnt - 7'd1;
          end else begin
            logic signed [FRAC_BITS+1:0] cap, nv;
            cap = (FRAC_BITS+2)'(1) << FRAC_BITS;
            if (dv_q > (DW+1)'(cap)) nv = cap;
            else nv = dv_q[FRAC_BITS+1:0];
            if (dv_neg) nv = -nv;
            if (state == S_DIVX) begin
              nx <= nv;
              dv_rem_n <= DW'(dy[32] ? 33'(-dy) : dy) << FRAC_BITS;
              dv_neg <= dy[32];
              dv_r <= '0;
              dv_q <= '0;
              dv_cnt <= 7'(DW);
              state <= S_DIVY;
            end else begin
              ny <= nv;
              dv_busy <= 1'b0;
              state <= S_SEPX;
            end
          end
        end
        S_SEPX: begin
          pos[0] <= sat32(72'(pos[0]) - mres);
          pos[2] <= sat32(72'(pos[2]) + mres);
          state <= S_SEPY;
        end
        S_SEPY: begin
          pos[1] <= sat32(72'(pos[1]) - mres);
          pos[3] <= sat32(72'(pos[3]) + mres);
          state <= S_DOTX;
        end
        S_DOTX: begin
          dot <= 66'(mres);
          state <= S_DOTY;
        end
        S_DOTY: begin
          logic signed [65:0] d;
          d = dot + 66'(mres);
          dot <= d;
          state <= (d > 0) ? S_WALL2 : S_IMP;
        end
        S_IMP: begin
          imp <= 66'(mres);
          state <= S_IMPX;
        end
        S_IMPX: begin
          vel[0] <= sat32(72'(vel[0]) + mres);
          vel[2] <= sat32(72'(vel[2]) - mres);
          state <= S_IMPY;
        end
        S_IMPY: begin
          vel[1] <= sat32(72'(vel[1]) + mres);
          vel[3] <= sat32(72'(vel[3]) - mres);
          state <= S_WALL2;
        end
        S_FRIC: begin
          vel[idx] <= sat32(mres);
          idx <= idx + 2'd1;
          if (idx == 2'd3) state <= S_DONE;
        end
        S_DONE: begin
          out_data.out_a_x <= pos[0];
          out_data.out_a_y <= pos[1];
          out_data.out_b_x <= pos[2];
          out_data.out_b_y <= pos[3];
          out_data.collided <= hit;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "two_ball_collision_step_unit_assert.svh"

  `TBC_ASSERT_NOW(a_ready_only_idle, in_ready, state == S_IDLE && !out_valid)
  `TBC_ASSERT_NEXT(a_done_gives_word, state == S_DONE, out_valid)
  `TBC_ASSERT_NOW(a_units_exclusive, sr_busy, !dv_busy)
  `TBC_ASSERT_NEXT(a_place_quick, in_valid && in_ready && in_data.opcode == OP_PLACE,
    state == S_DONE)

endmodule

// ===== dv/two_ball_collision_step_unit_tb.sv =====
`timescale 1ns / 1ps

module two_ball_collision_step_unit_tb;
  import tbc_pkg::*;

  localparam int FRAC = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  tbc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  tbc_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_RADIUS_A;
  logic [23:0] cfg_data = '0;

  two_ball_collision_step_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // pending input words and predicted frame results
  tbc_in_t  word_q[$];
  tbc_out_t frame_q[$];
  int       fails = 0;
  bit       no_idle = 0;   // phase without gaps on either side
  bit       stall_req = 0; // ask the receiver for one long hold-off

  // shadow of the block: registers and ball state (index 0 ball a, 1 ball b)
  logic [9:0]  sh_rad [2];
  logic [11:0] sh_fw, sh_fh;
  logic [23:0] sh_kspd;
  logic [16:0] sh_fric;
  logic signed [31:0] bx [2], by [2], bvx [2], bvy [2];

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // product of magnitudes, shifted, sign restored: truncates toward zero
  function automatic longint mul_trunc(longint a, longint b, int sh);
    logic [63:0]  ma, mb;
    logic [127:0] p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = ({64'd0, ma} * {64'd0, mb}) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // one axis against its two walls; the low wall wins on a tiny field
  task automatic wall_axis(inout logic signed [31:0] p, inout logic signed [31:0] v,
                           input logic [9:0] r, input logic [11:0] lim);
    longint lo, hi, s;
    lo = longint'(r) <<< FRAC;
    hi = (longint'(lim) - longint'(r)) <<< FRAC;
    s = mul_trunc((v < 0) ? -longint'(v) : longint'(v), BOUNCE_Q16, 16);
    if (longint'(p) < lo) begin
      p = clip32(lo);
      v = clip32(s);
    end else if (longint'(p) > hi) begin
      p = clip32(hi);
      v = clip32(-s);
    end
  endtask

  task automatic wall_all();
    for (int i = 0; i < 2; i++) begin
      wall_axis(bx[i], bvx[i], sh_rad[i], sh_fw);
      wall_axis(by[i], bvy[i], sh_rad[i], sh_fh);
    end
  endtask

  function automatic longint unit_norm(longint n);
    if (n > (64'sd1 <<< FRAC)) return 64'sd1 <<< FRAC;
    if (n < -(64'sd1 <<< FRAC)) return -(64'sd1 <<< FRAC);
    return n;
  endfunction

  // overlap test, separation and damped impulse; returns the collided flag
  function automatic bit resolve_contact();
    longint dx, dy, span, rsum, nx, ny, half, sx, sy, dot, imp, ix, iy;
    longint unsigned sq;
    dx = clip32(longint'(bx[1]) - longint'(bx[0]));
    dy = clip32(longint'(by[1]) - longint'(by[0]));
    sq = longint'(dx * dx) + longint'(dy * dy);
    span = int_sqrt(sq);
    rsum = (longint'(sh_rad[0]) + longint'(sh_rad[1])) <<< FRAC;
    if (span > rsum) return 1'b0;
    // coincident centers: no normal, so nothing to resolve
    if (span == 0) return 1'b1;
    nx = unit_norm((dx <<< FRAC) / span);
    ny = unit_norm((dy <<< FRAC) / span);
    half = (rsum - span) >>> 1;
    sx = mul_trunc(nx, half, FRAC);
    sy = mul_trunc(ny, half, FRAC);
    bx[0] = clip32(longint'(bx[0]) - sx);
    by[0] = clip32(longint'(by[0]) - sy);
    bx[1] = clip32(longint'(bx[1]) + sx);
    by[1] = clip32(longint'(by[1]) + sy);
    dot = mul_trunc(longint'(bvx[1]) - longint'(bvx[0]), nx, FRAC)
        + mul_trunc(longint'(bvy[1]) - longint'(bvy[0]), ny, FRAC);
    // moving apart already: separation only
    if (dot > 0) return 1'b1;
    imp = mul_trunc(dot, BOUNCE_Q16, 16);
    ix = mul_trunc(imp, nx, FRAC);
    iy = mul_trunc(imp, ny, FRAC);
    bvx[0] = clip32(longint'(bvx[0]) + ix);
    bvy[0] = clip32(longint'(bvy[0]) + iy);
    bvx[1] = clip32(longint'(bvx[1]) - ix);
    bvy[1] = clip32(longint'(bvy[1]) - iy);
    return 1'b1;
  endfunction

  // advance the shadow by one accepted word and queue the frame it yields
  task automatic predict_frame(input tbc_in_t w);
    tbc_out_t r;
    longint   mv, dt;
    logic [3:0] k;
    bit hit;
    hit = 1'b0;
    if (w.opcode == OP_PLACE) begin
      bx[w.ball_select]  = w.place_x;
      by[w.ball_select]  = w.place_y;
      bvx[w.ball_select] = w.place_vx;
      bvy[w.ball_select] = w.place_vy;
    end else begin
      dt = longint'(w.delta_time);
      mv = mul_trunc(longint'(sh_kspd), dt, 16);
      for (int i = 0; i < 2; i++) begin
        k = w.keys_down[4*i +: 4];
        if (k[0]) bx[i] = clip32(longint'(bx[i]) + mv);
        if (k[1]) bx[i] = clip32(longint'(bx[i]) - mv);
        if (k[2]) by[i] = clip32(longint'(by[i]) - mv);
        if (k[3]) by[i] = clip32(longint'(by[i]) + mv);
      end
      wall_all();
      for (int i = 0; i < 2; i++) begin
        bx[i] = clip32(longint'(bx[i]) + mul_trunc(bvx[i], dt, 16));
        by[i] = clip32(longint'(by[i]) + mul_trunc(bvy[i], dt, 16));
      end
      hit = resolve_contact();
      wall_all();
      for (int i = 0; i < 2; i++) begin
        bvx[i] = clip32(mul_trunc(bvx[i], longint'(sh_fric), 16));
        bvy[i] = clip32(mul_trunc(bvy[i], longint'(sh_fric), 16));
      end
    end
    r.out_a_x = bx[0];
    r.out_a_y = by[0];
    r.out_b_x = bx[1];
    r.out_b_y = by[1];
    r.collided = hit;
    frame_q.push_back(r);
  endtask

  // gap lengths: mostly short, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // driver: presents queued words, predicts each one as it is accepted
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_frame(in_data);
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (word_q.size() != 0) begin
        in_data <= word_q.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: random back-pressure, checks each taken frame result
  int  hold = 0;
  int  mism = 0;
  bit  stall_done = 0;
  always @(posedge clk) begin
    tbc_out_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_q.size() == 0) begin
          fails++;
          if (mism < 10) $display("unexpected frame result %p", out_data);
          mism++;
        end else begin
          e = frame_q.pop_front();
          if (out_data.out_a_x !== e.out_a_x || out_data.out_a_y !== e.out_a_y ||
              out_data.out_b_x !== e.out_b_x || out_data.out_b_y !== e.out_b_y ||
              out_data.collided !== e.collided) begin
            fails++;
            if (mism < 10)
              $display("frame mismatch: exp a(%0d,%0d) b(%0d,%0d) hit %0b, got a(%0d,%0d) b(%0d,%0d) hit %0b",
                       e.out_a_x, e.out_a_y, e.out_b_x, e.out_b_y, e.collided,
                       out_data.out_a_x, out_data.out_a_y, out_data.out_b_x,
                       out_data.out_b_y, out_data.collided);
            mism++;
          end
        end
      end
      // long hold-off: sender keeps offering, so the block backs up
      if (stall_req && !stall_done) begin
        stall_done <= 1'b1;
        hold <= 1500;
        out_ready <= 1'b0;
      end else if (hold > 0) begin
        hold <= hold - 1;
        out_ready <= 1'b0;
      end else begin
        hold <= pick_gap();
        out_ready <= 1'b1;
      end
    end
  end

  // register write while idle, mirrored into the shadow
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_RADIUS_A: sh_rad[0] = val[9:0];
      REG_RADIUS_B: sh_rad[1] = val[9:0];
      REG_FIELD_W:  sh_fw = val[11:0];
      REG_FIELD_H:  sh_fh = val[11:0];
      REG_KEY_SPD:  sh_kspd = val;
      REG_FRICTION: sh_fric = val[16:0];
      default: ;
    endcase
  endtask

  task automatic apply_regs(input int ra, input int rb, input int fw, input int fh,
                            input int ks, input int fr);
    write_reg(REG_RADIUS_A, 24'(ra));
    write_reg(REG_RADIUS_B, 24'(rb));
    write_reg(REG_FIELD_W, 24'(fw));
    write_reg(REG_FIELD_H, 24'(fh));
    write_reg(REG_KEY_SPD, 24'(ks));
    write_reg(REG_FRICTION, 24'(fr));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic tbc_in_t place_word(bit sel, int x, int y, int vx, int vy);
    tbc_in_t w;
    w = '0;
    w.opcode = OP_PLACE;
    w.ball_select = sel;
    w.place_x = x;
    w.place_y = y;
    w.place_vx = vx;
    w.place_vy = vy;
    w.delta_time = 16'($urandom);
    w.keys_down = 8'($urandom);
    return w;
  endfunction

  function automatic tbc_in_t tick_word(int dt, int k);
    tbc_in_t w;
    w = '0;
    w.opcode = OP_TICK;
    w.delta_time = 16'(dt);
    w.keys_down = 8'(k);
    w.ball_select = 1'($urandom);
    w.place_x = $urandom;
    w.place_y = $urandom;
    return w;
  endfunction

  function automatic int px(int p);
    return (p <<< 16) + $urandom_range(0, 65535);
  endfunction

  function automatic int rand_vel();
    return $urandom_range(0, 800 << 16) - (400 << 16);
  endfunction

  function automatic int in_field(int r, int lim);
    if (lim > 2 * r) return px($urandom_range(r, lim - r));
    return px($urandom_range(0, lim));
  endfunction

  // two balls placed close together, then a short run of frames
  task automatic queue_encounter();
    int ax, ay, reach, n;
    reach = sh_rad[0] + sh_rad[1] + 8;
    ax = in_field(sh_rad[0], sh_fw);
    ay = in_field(sh_rad[0], sh_fh);
    word_q.push_back(place_word(0, ax, ay, rand_vel(), rand_vel()));
    word_q.push_back(place_word(1, ax + $urandom_range(0, 2 * reach << 16) - (reach << 16),
                                ay + $urandom_range(0, 2 * reach << 16) - (reach << 16),
                                rand_vel(), rand_vel()));
    n = $urandom_range(3, 8);
    repeat (n)
      word_q.push_back(tick_word(($urandom_range(0, 19) == 0) ? $urandom
                                 : $urandom_range(0, 4000),
                                 ($urandom_range(0, 2) == 0) ? $urandom : 0));
  endtask

  task automatic queue_noise();
    if ($urandom_range(0, 1))
      word_q.push_back(place_word(1'($urandom), $urandom, $urandom, $urandom, $urandom));
    else
      word_q.push_back(tick_word($urandom, $urandom));
  endtask

  task automatic run_random(input int count);
    int start;
    start = word_q.size();
    while (word_q.size() - start < count)
      if ($urandom_range(0, 9) < 8) queue_encounter();
      else queue_noise();
  endtask

  // wait until the block has drained everything
  task automatic drain();
    while (word_q.size() != 0 || in_valid || frame_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    sh_rad[0] = 40; sh_rad[1] = 40;
    sh_fw = 800; sh_fh = 600;
    sh_kspd = 13107200; sh_fric = 64880;
    for (int i = 0; i < 2; i++) begin
      bx[i] = 0; by[i] = 0; bvx[i] = 0; bvy[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: head-on hit, separating pair, coincident centers, far apart
    word_q.push_back(place_word(0, 200 << 16, 300 << 16, 100 << 16, 0));
    word_q.push_back(place_word(1, 250 << 16, 310 << 16, -(100 << 16), 0));
    word_q.push_back(tick_word(1092, 8'h00));
    word_q.push_back(place_word(1, 230 << 16, 300 << 16, 200 << 16, 50 << 16));
    word_q.push_back(place_word(0, 200 << 16, 300 << 16, -(200 << 16), 0));
    word_q.push_back(tick_word(1092, 8'h00));
    word_q.push_back(place_word(1, 200 << 16, 300 << 16, 0, 0));
    word_q.push_back(place_word(0, 200 << 16, 300 << 16, 0, 0));
    word_q.push_back(tick_word(0, 8'h00));
    word_q.push_back(place_word(1, 700 << 16, 500 << 16, 0, 0));
    for (int b = 0; b < 8; b++) word_q.push_back(tick_word(2000, 1 << b));
    // extremes of positions and velocities, full frame time, all keys
    word_q.push_back(place_word(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
    word_q.push_back(place_word(1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    word_q.push_back(tick_word(16'hffff, 8'hff));
    word_q.push_back(tick_word(16'hffff, 8'h00));
    run_random(340);
    // let the receiver hold off while words keep coming
    while (word_q.size() > 150) @(posedge clk);
    stall_req = 1'b1;
    drain();

    // small balls in the biggest field, fastest keys, no friction loss
    apply_regs(1, 1, 4095, 4095, 24'hffffff, 65536);
    no_idle = 1'b1;
    run_random(340);
    drain();
    no_idle = 1'b0;

    // largest balls in the smallest field, keys dead, friction stops all
    apply_regs(1023, 1023, 1, 1, 0, 0);
    run_random(340);
    drain();

    // friction above one amplifies
    apply_regs($urandom_range(5, 200), $urandom_range(5, 200), $urandom_range(300, 2000),
               $urandom_range(300, 2000), $urandom_range(0, 24'hffffff), 17'h1ffff);
    run_random(340);
    drain();

    apply_regs($urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(1, 4095),
               $urandom_range(1, 4095), $urandom, $urandom_range(0, 65536));
    run_random(340);
    drain();

    repeat (300) @(posedge clk);
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== two_ball_collision_step_unit.f =====
+incdir+hdl
hdl/tbc_pkg.sv
hdl/two_ball_collision_step_unit.sv
dv/two_ball_collision_step_unit_tb.sv
